### design/sagp_pkg.sv
package sagp_pkg;

  typedef struct packed {
    logic signed [23:0] source_x;
    logic signed [23:0] source_y;
    logic signed [23:0] source_z;
    logic [8:0]         base_volume;
  } sagp_in_t;

  typedef struct packed {
    logic [15:0]       gain;
    logic [6:0]        drive_volume;
    logic signed [7:0] pan;
  } sagp_out_t;

  typedef enum logic [2:0] {
    CFG_LISTENER_X  = 3'd0,
    CFG_LISTENER_Y  = 3'd1,
    CFG_LISTENER_Z  = 3'd2,
    CFG_FACING_X    = 3'd3,
    CFG_FACING_Z    = 3'd4,
    CFG_NEAR_DIST   = 3'd5,
    CFG_FAR_DIST    = 3'd6
  } sagp_cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // square root unit: 58-bit radicand, one result bit per stage
  localparam int SQRT_IN_W  = 58;
  localparam int SQRT_OUT_W = 29;
  localparam int SQRT_REM_W = 32;

  localparam int GAIN_Q_W   = 15;
  localparam int PAN_STEPS  = 8;
  localparam int DIV_STAGES = 15;

  localparam logic [22:0] NEAR_RESET = 23'd2560;
  localparam logic [22:0] FAR_RESET  = 23'd256000;
  localparam logic [15:0] Q15_ONE    = 16'd32768;
  localparam logic [8:0]  VOL_FULL   = 9'd256;
  localparam logic [6:0]  PAN_MAX    = 7'd127;
  localparam logic signed [16:0] RIGHT_ONE = 17'sd16384;

endpackage

### design/spatial_audio_gain_and_pan_top.sv
// Distance gain and stereo pan, one sound source per request. Each request
// carries a source position and base volume; the result gives the Q1.15
// distance gain (1.0 inside near_distance, 0 at or past far_distance,
// near/distance between), the drive volume 0..127 and the pan -127..127
// from the source's horizontal offset on the listener's right axis.
// Fully pipelined: one request per cycle while in_stall is low. The depth is
// set by the 29-stage square root units (3D distance, horizontal distance,
// right axis length) and the 15-stage gain divider. A two-entry output buffer
// keeps the pipeline moving while a result waits; in_stall is registered.
// Configuration must be written only while idle; not enforced by the block.
module spatial_audio_gain_and_pan_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sagp_pkg::sagp_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sagp_pkg::sagp_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [sagp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sagp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SQ   = sagp_pkg::SQRT_OUT_W;
  localparam int DS   = sagp_pkg::DIV_STAGES;
  localparam int GQ   = sagp_pkg::GAIN_Q_W;
  localparam int PS   = sagp_pkg::PAN_STEPS;
  localparam int LAT  = 4 + SQ + 1 + DS + 2;

  typedef struct packed {
    logic [8:0]         vol;
    logic signed [41:0] dot;
    logic               hz;
  } sagp_side_t;

  typedef struct packed {
    logic [37:0] grem;
    logic [14:0] gq;
    logic [25:0] dval;
    logic [60:0] prem;
    logic [6:0]  pq;
    logic        psat;
    logic [52:0] den;
    logic        le_near;
    logic        ge_far;
    logic        neg;
    logic        hz;
    logic [8:0]  vol;
  } sagp_div_t;

  // configuration
  logic signed [23:0] listener_x_r, listener_y_r, listener_z_r;
  logic signed [15:0] facing_x_r, facing_z_r;
  logic [22:0]        near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listener_x_r <= '0;
      listener_y_r <= '0;
      listener_z_r <= '0;
      facing_x_r   <= '0;
      facing_z_r   <= '0;
      near_r       <= sagp_pkg::NEAR_RESET;
      far_r        <= sagp_pkg::FAR_RESET;
    end else if (cfg_we) begin
      unique case (sagp_pkg::sagp_cfg_idx_t'(cfg_index))
        sagp_pkg::CFG_LISTENER_X: listener_x_r <= cfg_wdata;
        sagp_pkg::CFG_LISTENER_Y: listener_y_r <= cfg_wdata;
        sagp_pkg::CFG_LISTENER_Z: listener_z_r <= cfg_wdata;
        sagp_pkg::CFG_FACING_X:   facing_x_r   <= cfg_wdata[15:0];
        sagp_pkg::CFG_FACING_Z:   facing_z_r   <= cfg_wdata[15:0];
        sagp_pkg::CFG_NEAR_DIST:  near_r       <= cfg_wdata[22:0];
        sagp_pkg::CFG_FAR_DIST:   far_r        <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // valid bits travel alongside the stages
  logic vld_r [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // S1: offsets, right axis with short-axis fallback, volume clamp
  logic signed [24:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [16:0] s1_rx_r, s1_rz_r;
  logic [8:0]         s1_vol_r;
  logic signed [16:0] rx_raw, rz_raw;
  logic               short_axis;

  always_comb begin
    rx_raw = 17'(facing_z_r);
    rz_raw = -17'(facing_x_r);
    // length^2 below 3: both components in -1..1
    short_axis = (rx_raw >= -17'sd1) && (rx_raw <= 17'sd1) &&
                 (rz_raw >= -17'sd1) && (rz_raw <= 17'sd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r  <= 25'(in_data.source_x) - 25'(listener_x_r);
      s1_dy_r  <= 25'(in_data.source_y) - 25'(listener_y_r);
      s1_dz_r  <= 25'(in_data.source_z) - 25'(listener_z_r);
      s1_rx_r  <= short_axis ? sagp_pkg::RIGHT_ONE : rx_raw;
      s1_rz_r  <= short_axis ? 17'sd0 : rz_raw;
      s1_vol_r <= (in_data.base_volume > sagp_pkg::VOL_FULL) ? sagp_pkg::VOL_FULL
                                                             : in_data.base_volume;
    end
  end

  // S2: squares and projections
  logic [24:0]        ax, ay, az;
  logic [16:0]        arx, arz;
  logic [48:0]        s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic signed [41:0] s2_px_r, s2_pz_r;
  logic [31:0]        s2_rsq_r;
  logic [8:0]         s2_vol_r;

  always_comb begin
    ax  = s1_dx_r[24] ? 25'(-s1_dx_r) : 25'(s1_dx_r);
    ay  = s1_dy_r[24] ? 25'(-s1_dy_r) : 25'(s1_dy_r);
    az  = s1_dz_r[24] ? 25'(-s1_dz_r) : 25'(s1_dz_r);
    arx = s1_rx_r[16] ? 17'(-s1_rx_r) : 17'(s1_rx_r);
    arz = s1_rz_r[16] ? 17'(-s1_rz_r) : 17'(s1_rz_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r <= 49'(ax) * 49'(ax);
      s2_sqy_r <= 49'(ay) * 49'(ay);
      s2_sqz_r <= 49'(az) * 49'(az);
      s2_px_r  <= 42'(s1_dx_r) * 42'(s1_rx_r);
      s2_pz_r  <= 42'(s1_dz_r) * 42'(s1_rz_r);
      s2_rsq_r <= 32'(arx) * 32'(arx) + 32'(arz) * 32'(arz);
      s2_vol_r <= s1_vol_r;
    end
  end

  // S3: horizontal sum and dot product
  logic [49:0]        s3_hsq_r;
  logic [48:0]        s3_sqy_r;
  logic signed [41:0] s3_dot_r;
  logic [31:0]        s3_rsq_r;
  logic [8:0]         s3_vol_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_hsq_r <= 50'(s2_sqx_r) + 50'(s2_sqz_r);
      s3_sqy_r <= s2_sqy_r;
      s3_dot_r <= s2_px_r + s2_pz_r;
      s3_rsq_r <= s2_rsq_r;
      s3_vol_r <= s2_vol_r;
    end
  end

  // S4: 3D sum
  logic [49:0] s4_tot_r, s4_hsq_r;
  logic [31:0] s4_rsq_r;
  sagp_side_t  s4_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tot_r      <= s3_hsq_r + 50'(s3_sqy_r);
      s4_hsq_r      <= s3_hsq_r;
      s4_rsq_r      <= s3_rsq_r;
      s4_side_r.vol <= s3_vol_r;
      s4_side_r.dot <= s3_dot_r;
      s4_side_r.hz  <= (s3_hsq_r != '0);
    end
  end

  // square roots
  logic [SQ-1:0] dist_root, hq_root, rq_root;

  sagp_isqrt u_sqrt_dist (
    .clk      (clk),
    .en       (en),
    .radicand ({8'd0, s4_tot_r}),
    .root     (dist_root)
  );

  sagp_isqrt u_sqrt_horiz (
    .clk      (clk),
    .en       (en),
    .radicand ({s4_hsq_r, 8'd0}),
    .root     (hq_root)
  );

  sagp_isqrt u_sqrt_right (
    .clk      (clk),
    .en       (en),
    .radicand ({10'd0, s4_rsq_r, 16'd0}),
    .root     (rq_root)
  );

  sagp_side_t side_r [SQ];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s4_side_r;
      for (int i = 1; i < SQ; i++) side_r[i] <= side_r[i-1];
    end
  end

  // P1: range tests, pan denominator and numerator
  sagp_div_t   p1_r;
  sagp_div_t   p1_nxt;
  logic [41:0] mdot;
  logic [48:0] mdot127;

  always_comb begin
    mdot    = side_r[SQ-1].dot[41] ? 42'(-side_r[SQ-1].dot) : 42'(side_r[SQ-1].dot);
    mdot127 = {mdot, 7'd0} - 49'(mdot);
    p1_nxt.grem    = {near_r, 15'd0};
    p1_nxt.gq      = '0;
    p1_nxt.dval    = dist_root[25:0];
    p1_nxt.prem    = {mdot127, 12'd0};
    p1_nxt.pq      = '0;
    p1_nxt.psat    = 1'b0;
    p1_nxt.den     = 53'(rq_root[23:0]) * 53'(hq_root);
    p1_nxt.le_near = dist_root[25:0] <= 26'(near_r);
    p1_nxt.ge_far  = dist_root[25:0] >= 26'(far_r);
    p1_nxt.neg     = side_r[SQ-1].dot[41];
    p1_nxt.hz      = side_r[SQ-1].hz;
    p1_nxt.vol     = side_r[SQ-1].vol;
  end

  always_ff @(posedge clk) begin
    if (en) p1_r <= p1_nxt;
  end

  // restoring dividers: gain one bit per stage, pan saturation test then 7 bits
  sagp_div_t dv_r  [DS];
  sagp_div_t dv_nxt[DS];

  always_comb begin
    for (int k = 0; k < DS; k++) begin
      sagp_div_t   cur;
      logic [40:0] gtrial;
      logic [61:0] ptrial;
      if (k == 0) cur = p1_r;
      else        cur = dv_r[k-1];
      dv_nxt[k] = cur;
      gtrial = 41'(cur.dval) << (GQ - 1 - k);
      if (41'(cur.grem) >= gtrial) begin
        dv_nxt[k].grem           = cur.grem - 38'(gtrial);
        dv_nxt[k].gq[GQ - 1 - k] = 1'b1;
      end
      if (k == 0) begin
        ptrial = 62'(cur.den) << (PS - 1);
        dv_nxt[k].psat = 62'(cur.prem) >= ptrial;
      end else if (k < PS) begin
        ptrial = 62'(cur.den) << (PS - 1 - k);
        if (62'(cur.prem) >= ptrial) begin
          dv_nxt[k].prem           = cur.prem - 61'(ptrial);
          dv_nxt[k].pq[PS - 1 - k] = 1'b1;
        end
      end else begin
        ptrial = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DS; k++) dv_r[k] <= dv_nxt[k];
    end
  end

  // F1: select gain and pan
  logic [15:0]       f1_gain_r, f1_gain_nxt;
  logic signed [7:0] f1_pan_r, f1_pan_nxt;
  logic [8:0]        f1_vol_r;
  logic signed [7:0] pan_mag;

  always_comb begin
    priority if (dv_r[DS-1].le_near) f1_gain_nxt = sagp_pkg::Q15_ONE;
    else if (dv_r[DS-1].ge_far)      f1_gain_nxt = '0;
    else                             f1_gain_nxt = {1'b0, dv_r[DS-1].gq};
    pan_mag = dv_r[DS-1].psat ? 8'(sagp_pkg::PAN_MAX) : 8'(dv_r[DS-1].pq);
    // zero horizontal distance: quotient is ignored, pan stays centered
    if (!dv_r[DS-1].hz)       f1_pan_nxt = '0;
    else if (dv_r[DS-1].neg)  f1_pan_nxt = -pan_mag;
    else                      f1_pan_nxt = pan_mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_gain_r <= f1_gain_nxt;
      f1_pan_r  <= f1_pan_nxt;
      f1_vol_r  <= dv_r[DS-1].vol;
    end
  end

  // F2: volume times gain
  logic [24:0]       f2_vg_r;
  logic [15:0]       f2_gain_r;
  logic signed [7:0] f2_pan_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_vg_r   <= 25'(f1_vol_r) * 25'(f1_gain_r);
      f2_gain_r <= f1_gain_r;
      f2_pan_r  <= f1_pan_r;
    end
  end

  sagp_pkg::sagp_out_t pipe_out;
  logic [31:0]         vg127;

  always_comb begin
    vg127 = 32'(f2_vg_r) * 32'd127;
    pipe_out.gain         = f2_gain_r;
    pipe_out.drive_volume = vg127[29:23];
    pipe_out.pan          = f2_pan_r;
  end

  // output register plus skid entry
  logic                out_v_r, out_v_nxt, skid_v_nxt;
  sagp_pkg::sagp_out_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;
  logic                take;

  always_comb begin
    take       = !out_v_r || !out_stall;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (vld_r[LAT-1]) begin
      if (take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pipe_out;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = pipe_out;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

### design/sagp_isqrt.sv
module sagp_isqrt (
  input  logic                             clk,
  input  logic                             en,
  input  logic [sagp_pkg::SQRT_IN_W-1:0]   radicand,
  output logic [sagp_pkg::SQRT_OUT_W-1:0]  root
);

  localparam int IW = sagp_pkg::SQRT_IN_W;
  localparam int OW = sagp_pkg::SQRT_OUT_W;
  localparam int RW = sagp_pkg::SQRT_REM_W;

  logic [RW-1:0] rem_r   [OW];
  logic [OW-1:0] root_r  [OW];
  logic [IW-1:0] rad_r   [OW];
  logic [RW-1:0] rem_nxt [OW];
  logic [OW-1:0] root_nxt[OW];
  logic [IW-1:0] rad_nxt [OW];

  // restoring digit recurrence: bring down two radicand bits, try root*4+1
  always_comb begin
    for (int k = 0; k < OW; k++) begin
      logic [RW-1:0] rem_in;
      logic [OW-1:0] root_in;
      logic [IW-1:0] rad_in;
      logic [RW+1:0] t;
      logic [RW+1:0] trial;
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = radicand;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        rad_in  = rad_r[k-1];
      end
      t     = {rem_in, rad_in[IW-1 -: 2]};
      trial = (RW+2)'({root_in, 2'b01});
      if (t >= trial) begin
        rem_nxt[k]  = RW'(t - trial);
        root_nxt[k] = {root_in[OW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = RW'(t);
        root_nxt[k] = {root_in[OW-2:0], 1'b0};
      end
      rad_nxt[k] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < OW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
      end
    end
  end

  assign root = root_r[OW-1];

endmodule
